// ===== rtl/pwmc_pkg.sv =====
`default_nettype none

package pwmc_pkg;

   localparam int WINDOWS     = 4;
   localparam int WIN_IDX_W   = 2;
   localparam int CNT_W       = 10;
   localparam int HOLD_RESET  = 20;

   typedef enum logic [2:0] {
      MODE_IDLE      = 3'd0,
      MODE_HOLD_UP   = 3'd1,
      MODE_HOLD_DOWN = 3'd2,
      MODE_MAN_UP    = 3'd3,
      MODE_MAN_DOWN  = 3'd4,
      MODE_OT_UP     = 3'd5,
      MODE_OT_DOWN   = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      MOT_OFF  = 2'd0,
      MOT_UP   = 2'd1,
      MOT_DOWN = 2'd2
   } motor_type;

   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

endpackage

`default_nettype wire

// ===== rtl/power_window_mode_controller.sv =====
// Channel  Direction  Handshake            Payload
// req_     in         req_valid/req_ready  window sample: index, switches, limits, lock toggle
// rsp_     out        rsp_valid/rsp_ready  window_out, motor_cmd, one_touch, locked
// csr_     in         csr_valid/csr_ready  hold_ticks (10 bits)
//
// One request per cycle while the result is not stalled: input register, one pass of
// next-state logic, result register; a request's result is valid once it reaches the result register.
// Per-window state is written when a request moves into the result register,
// so the next request for the same window sees it in the following cycle.
// Reset (synchronous) idles all windows, clears the lock, hold_ticks = 20.
// A stalled result holds the input register only once both stages are full.
`default_nettype none

module power_window_mode_controller
   import pwmc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [WIN_IDX_W-1:0] req_window_index,
   input  wire logic                 req_own_up,
   input  wire logic                 req_own_down,
   input  wire logic                 req_remote_up,
   input  wire logic                 req_remote_down,
   input  wire logic                 req_top_limit,
   input  wire logic                 req_bottom_limit,
   input  wire logic                 req_lock_toggle,

   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [WIN_IDX_W-1:0]      rsp_window_out,
   output logic [1:0]                rsp_motor_cmd,
   output logic                      rsp_one_touch,
   output logic                      rsp_locked,

   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CNT_W-1:0]     csr_hold_ticks
);

   // input stage
   logic                 s1_valid_ff, s1_valid_in;
   logic [WIN_IDX_W-1:0] s1_idx_ff;
   logic                 s1_own_up_ff, s1_own_down_ff;
   logic                 s1_rem_up_ff, s1_rem_down_ff;
   logic                 s1_top_ff, s1_bot_ff, s1_toggle_ff;

   // result stage
   logic                 out_valid_ff, out_valid_in;
   logic [WIN_IDX_W-1:0] out_idx_ff;
   motor_type            out_mot_ff, out_mot_in;
   logic                 out_ot_ff, out_ot_in;
   logic                 out_lock_ff;

   // state
   logic [CNT_W-1:0]     hold_ticks_ff;
   logic                 lock_ff, lock_in;
   mode_type             mode_ff [WINDOWS];
   logic [CNT_W-1:0]     cnt_ff  [WINDOWS];
   motor_type            mot_ff  [WINDOWS];

   logic                 accept;
   logic                 advance;
   logic                 win_ok;
   mode_type             mode_in;
   logic [CNT_W-1:0]     cnt_in;
   motor_type            mot_in;

   assign advance   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);
   assign lock_in      = lock_ff ^ s1_toggle_ff;
   assign win_ok       = (32'(s1_idx_ff) < WINDOWS);

   // per-window update for the request in the input stage
   always_comb begin
      logic     req_up;
      logic     req_down;
      logic     dir_lim;
      logic [CNT_W-1:0] cnt_inc;
      mode_type mode_cur;

      req_up   = (s1_own_up_ff && !lock_in) || (s1_idx_ff != '0 && s1_rem_up_ff);
      req_down = (s1_own_down_ff && !lock_in) || (s1_idx_ff != '0 && s1_rem_down_ff);
      mode_cur = mode_ff[s1_idx_ff];
      mode_in  = mode_cur;
      cnt_in   = cnt_ff[s1_idx_ff];
      mot_in   = mot_ff[s1_idx_ff];
      dir_lim  = (mode_cur == MODE_HOLD_UP) ? s1_top_ff : s1_bot_ff;
      cnt_inc  = (cnt_in < COUNT_MAX) ? cnt_in + 1'b1 : cnt_in;

      // a limit stops only motion toward it
      if ((mot_in == MOT_UP && s1_top_ff) || (mot_in == MOT_DOWN && s1_bot_ff)) begin
         mot_in = MOT_OFF;
      end

      case (mode_cur)
         MODE_HOLD_UP, MODE_HOLD_DOWN: begin
            if (dir_lim) begin
               mode_in = MODE_IDLE;
               mot_in  = MOT_OFF;
            end else begin
               cnt_in = cnt_inc;
               if (cnt_inc >= hold_ticks_ff) begin
                  if (mode_cur == MODE_HOLD_UP) begin
                     mode_in = req_up ? MODE_MAN_UP : MODE_OT_UP;
                     mot_in  = MOT_UP;
                  end else begin
                     mode_in = req_down ? MODE_MAN_DOWN : MODE_OT_DOWN;
                     mot_in  = MOT_DOWN;
                  end
               end
            end
         end
         MODE_MAN_UP: begin
            if (!req_up || s1_top_ff) begin
               mode_in = MODE_IDLE;
               mot_in  = MOT_OFF;
            end else begin
               mot_in = MOT_UP;
            end
         end
         MODE_MAN_DOWN: begin
            if (!req_down || s1_bot_ff) begin
               mode_in = MODE_IDLE;
               mot_in  = MOT_OFF;
            end else begin
               mot_in = MOT_DOWN;
            end
         end
         default: begin
            // idle, one-touch, or an unknown code (treated as idle)
            if (mode_cur != MODE_OT_UP && mode_cur != MODE_OT_DOWN) begin
               mode_in = MODE_IDLE;
               mot_in  = MOT_OFF;
            end else if (mot_in == MOT_OFF) begin
               mode_in = MODE_IDLE;
            end
            if (req_up && !s1_top_ff) begin
               mode_in = MODE_HOLD_UP;
               cnt_in  = '0;
            end else if (req_down && !s1_bot_ff) begin
               mode_in = MODE_HOLD_DOWN;
               cnt_in  = '0;
            end
         end
      endcase

      if (win_ok) begin
         out_mot_in = mot_in;
         out_ot_in  = (mode_in == MODE_OT_UP || mode_in == MODE_OT_DOWN);
      end else begin
         out_mot_in = MOT_OFF;
         out_ot_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         lock_ff       <= 1'b0;
         hold_ticks_ff <= CNT_W'(HOLD_RESET);
         for (int k = 0; k < WINDOWS; k++) begin
            mode_ff[k] <= MODE_IDLE;
            cnt_ff[k]  <= '0;
            mot_ff[k]  <= MOT_OFF;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            hold_ticks_ff <= csr_hold_ticks;
         end
         if (advance) begin
            lock_ff <= lock_in;
            if (win_ok) begin
               mode_ff[s1_idx_ff] <= mode_in;
               cnt_ff[s1_idx_ff]  <= cnt_in;
               mot_ff[s1_idx_ff]  <= mot_in;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff      <= req_window_index;
         s1_own_up_ff   <= req_own_up;
         s1_own_down_ff <= req_own_down;
         s1_rem_up_ff   <= req_remote_up;
         s1_rem_down_ff <= req_remote_down;
         s1_top_ff      <= req_top_limit;
         s1_bot_ff      <= req_bottom_limit;
         s1_toggle_ff   <= req_lock_toggle;
      end
      if (advance) begin
         out_idx_ff  <= s1_idx_ff;
         out_mot_ff  <= out_mot_in;
         out_ot_ff   <= out_ot_in;
         out_lock_ff <= lock_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_window_out = out_idx_ff;
   assign rsp_motor_cmd  = out_mot_ff;
   assign rsp_one_touch  = out_ot_ff;
   assign rsp_locked     = out_lock_ff;

   // one-touch is only reported while the motor is driving
   a_ot_moving: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_one_touch |-> rsp_motor_cmd != MOT_OFF)
      else $error("one-touch reported with motor off");

   // a request in the input stage with a free result slot moves on
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_valid_ff |=> out_valid_ff)
      else $error("request not moved to result stage");

   // the lock only changes when a request carrying a toggle is processed
   a_lock_change: assert property (@(posedge clock) disable iff (reset)
      !(advance && s1_toggle_ff) |=> $stable(lock_ff))
      else $error("lock changed without a toggle");

endmodule

`default_nettype wire

// ===== sim/power_window_mode_controller_tb.sv =====
`default_nettype none

module power_window_mode_controller_tb;
   import pwmc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;

   // one window sample; the low seven bits run
   // own_up, own_down, remote_up, remote_down, top_limit, bottom_limit, lock_toggle
   typedef struct packed {
      logic [WIN_IDX_W-1:0] window_index;
      logic                 own_up;
      logic                 own_down;
      logic                 remote_up;
      logic                 remote_down;
      logic                 top_limit;
      logic                 bottom_limit;
      logic                 lock_toggle;
   } window_sample_type;

   typedef struct {
      logic [WIN_IDX_W-1:0] window_out;
      logic [1:0]           motor_cmd;
      logic                 one_touch;
      logic                 locked;
   } motor_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [WIN_IDX_W-1:0] req_window_index = '0;
   logic                 req_own_up = 1'b0;
   logic                 req_own_down = 1'b0;
   logic                 req_remote_up = 1'b0;
   logic                 req_remote_down = 1'b0;
   logic                 req_top_limit = 1'b0;
   logic                 req_bottom_limit = 1'b0;
   logic                 req_lock_toggle = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [WIN_IDX_W-1:0] rsp_window_out;
   logic [1:0]           rsp_motor_cmd;
   logic                 rsp_one_touch;
   logic                 rsp_locked;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CNT_W-1:0]     csr_hold_ticks = '0;

   // predicted controller state
   mode_type         win_mode [WINDOWS];
   logic [CNT_W-1:0] win_count [WINDOWS];
   motor_type        win_motor [WINDOWS];
   logic             lock_state;
   logic [CNT_W-1:0] hold_cfg;

   motor_result_type expected_cmds[$];

   // per-window press scripts for the random sequences
   int press_dir [WINDOWS];
   int press_left [WINDOWS];
   bit press_remote [WINDOWS];

   int  errors = 0;
   int  sent_count = 0;
   int  cycle_count = 0;
   bit  gaps_on = 1'b1;
   int  stall_ticket = 0;
   int  stall_len = 0;
   int  stall_seen = 0;
   int  stall_left = 0;

   power_window_mode_controller u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_window_index (req_window_index),
      .req_own_up       (req_own_up),
      .req_own_down     (req_own_down),
      .req_remote_up    (req_remote_up),
      .req_remote_down  (req_remote_down),
      .req_top_limit    (req_top_limit),
      .req_bottom_limit (req_bottom_limit),
      .req_lock_toggle  (req_lock_toggle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_window_out   (rsp_window_out),
      .rsp_motor_cmd    (rsp_motor_cmd),
      .rsp_one_touch    (rsp_one_touch),
      .rsp_locked       (rsp_locked),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_hold_ticks   (csr_hold_ticks)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic void predict_motor_cmd(input window_sample_type s);
      motor_result_type r;
      mode_type         md;
      motor_type        mt;
      logic [CNT_W-1:0] ct;
      logic             up_req;
      logic             down_req;
      logic             going_up;
      int               w;
      w = int'(s.window_index);
      if (s.lock_toggle) lock_state = ~lock_state;
      r.window_out = s.window_index;
      r.locked     = lock_state;
      r.motor_cmd  = MOT_OFF;
      r.one_touch  = 1'b0;
      if (w < WINDOWS) begin
         up_req   = (s.own_up && !lock_state) || (w != 0 && s.remote_up);
         down_req = (s.own_down && !lock_state) || (w != 0 && s.remote_down);
         md = win_mode[w];
         mt = win_motor[w];
         ct = win_count[w];
         // a limit cuts only motion toward it
         if ((mt == MOT_UP && s.top_limit) || (mt == MOT_DOWN && s.bottom_limit)) mt = MOT_OFF;
         case (md)
            MODE_HOLD_UP, MODE_HOLD_DOWN: begin
               going_up = (md == MODE_HOLD_UP);
               if (going_up ? s.top_limit : s.bottom_limit) begin
                  md = MODE_IDLE;
                  mt = MOT_OFF;
               end else begin
                  if (ct != COUNT_MAX) ct = ct + 1'b1;
                  if (ct >= hold_cfg) begin
                     if (going_up) begin
                        md = up_req ? MODE_MAN_UP : MODE_OT_UP;
                        mt = MOT_UP;
                     end else begin
                        md = down_req ? MODE_MAN_DOWN : MODE_OT_DOWN;
                        mt = MOT_DOWN;
                     end
                  end
               end
            end
            MODE_MAN_UP: begin
               if (!up_req || s.top_limit) begin
                  md = MODE_IDLE;
                  mt = MOT_OFF;
               end else begin
                  mt = MOT_UP;
               end
            end
            MODE_MAN_DOWN: begin
               if (!down_req || s.bottom_limit) begin
                  md = MODE_IDLE;
                  mt = MOT_OFF;
               end else begin
                  mt = MOT_DOWN;
               end
            end
            default: begin
               if (md != MODE_OT_UP && md != MODE_OT_DOWN) begin
                  md = MODE_IDLE;
                  mt = MOT_OFF;
               end else if (mt == MOT_OFF) begin
                  md = MODE_IDLE;
               end
               if (up_req && !s.top_limit) begin
                  md = MODE_HOLD_UP;
                  ct = '0;
               end else if (down_req && !s.bottom_limit) begin
                  md = MODE_HOLD_DOWN;
                  ct = '0;
               end
            end
         endcase
         win_mode[w]  = md;
         win_motor[w] = mt;
         win_count[w] = ct;
         r.motor_cmd  = mt;
         r.one_touch  = (md == MODE_OT_UP || md == MODE_OT_DOWN);
      end
      expected_cmds.push_back(r);
   endfunction

   // entered and left at a falling edge
   task automatic send_sample(input window_sample_type s);
      if (gaps_on && $urandom_range(99) < 4) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_window_index <= s.window_index;
      req_own_up       <= s.own_up;
      req_own_down     <= s.own_down;
      req_remote_up    <= s.remote_up;
      req_remote_down  <= s.remote_down;
      req_top_limit    <= s.top_limit;
      req_bottom_limit <= s.bottom_limit;
      req_lock_toggle  <= s.lock_toggle;
      do @(posedge clock); while (!req_ready);
      predict_motor_cmd(s);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_cmds.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_hold_ticks(input logic [CNT_W-1:0] value);
      wait_idle();
      csr_valid      <= 1'b1;
      csr_hold_ticks <= value;
      do @(posedge clock); while (!csr_ready);
      hold_cfg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly scripted presses of random length, with stray limits, lock events and noise
   task automatic run_switch_sequences(input int count, input int max_press);
      window_sample_type s;
      int                w;
      for (int n = 0; n < count; n++) begin
         w = $urandom_range(WINDOWS - 1);
         if (press_left[w] == 0) begin
            press_dir[w]    = ($urandom_range(99) < 60) ? $urandom_range(1, 2) : 0;
            press_left[w]   = $urandom_range(1, max_press);
            press_remote[w] = 1'($urandom_range(1));
         end
         press_left[w]--;
         s = '0;
         s.window_index = WIN_IDX_W'(w);
         if (press_dir[w] == 1) begin
            if (press_remote[w]) s.remote_up = 1'b1;
            else s.own_up = 1'b1;
         end else if (press_dir[w] == 2) begin
            if (press_remote[w]) s.remote_down = 1'b1;
            else s.own_down = 1'b1;
         end
         s.top_limit    = ($urandom_range(99) < 5);
         s.bottom_limit = ($urandom_range(99) < 5);
         s.lock_toggle  = ($urandom_range(99) < 3);
         if ($urandom_range(99) < 8) s = (WIN_IDX_W + 7)'($urandom_range(511));
         send_sample(s);
      end
   endtask

   task automatic test_reset_hold();
      // reset value of hold_ticks is 20: 21 ticks held must end in manual up
      repeat (21) send_sample({2'd1, 7'b0010000});
      send_sample({2'd1, 7'b0000000});
   endtask

   task automatic test_directed();
      write_hold_ticks(10'd2);
      send_sample({2'd1, 7'b1000000});
      send_sample({2'd1, 7'b1000000});
      send_sample({2'd1, 7'b1000000});   // still held: manual up
      send_sample({2'd1, 7'b0000000});   // release stops manual
      send_sample({2'd2, 7'b0001000});
      send_sample({2'd2, 7'b0000000});
      send_sample({2'd2, 7'b0000000});   // released in hold: one-touch down
      send_sample({2'd2, 7'b1000000});   // new press during one-touch, motor keeps going
      send_sample({2'd2, 7'b0000100});   // top limit abandons the up hold
      send_sample({2'd0, 7'b0010000});   // remote has no effect on the driver window
      send_sample({2'd0, 7'b1100001});   // lock on, own switches blocked
      send_sample({2'd3, 7'b1001000});
      send_sample({2'd3, 7'b0000000});
      send_sample({2'd3, 7'b0000000});
      send_sample({2'd3, 7'b0000010});   // limit acts while locked
      send_sample({2'd3, 7'b0001010});   // press refused at its limit
      send_sample({2'd3, 7'b0011001});   // unlock; up wins over down
      send_sample({2'd3, 7'b1111111});
      send_sample({2'd0, 7'b1111111});
      // zero hold acts as one tick
      write_hold_ticks(10'd0);
      send_sample({2'd1, 7'b0100000});
      send_sample({2'd1, 7'b0100000});
      send_sample({2'd1, 7'b1000000});
      send_sample({2'd1, 7'b0000000});
   endtask

   task automatic test_random_holds();
      write_hold_ticks(10'd1);
      run_switch_sequences(100, 5);
      write_hold_ticks(10'd3);
      run_switch_sequences(100, 9);
      write_hold_ticks(CNT_W'($urandom_range(2, 12)));
      run_switch_sequences(100, 2 * int'(hold_cfg) + 3);
   endtask

   task automatic test_longest_hold();
      write_hold_ticks(10'd1023);
      // remote press so the lock state does not matter
      repeat (1024) send_sample({2'd2, 7'b0010000});
      send_sample({2'd2, 7'b0000000});
   endtask

   task automatic test_backpressure();
      write_hold_ticks(10'd2);
      stall_len = 80;
      stall_ticket++;
      run_switch_sequences(60, 7);
      // sender waits here for every response
      wait_idle();
      run_switch_sequences(40, 7);
   endtask

   task automatic test_no_gaps();
      write_hold_ticks(CNT_W'($urandom_range(1, 6)));
      gaps_on = 1'b0;
      run_switch_sequences(150, 2 * int'(hold_cfg) + 3);
      gaps_on = 1'b1;
   endtask

   always @(negedge clock) begin
      if (stall_ticket != stall_seen) begin
         stall_seen <= stall_ticket;
         stall_left <= stall_len;
         rsp_ready  <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= !(gaps_on && $urandom_range(99) < 7);
      end
   end

   always @(posedge clock) begin
      motor_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_cmds.size() == 0) begin
            $error("response for window %0d with no request pending", rsp_window_out);
            errors++;
         end else begin
            exp_r = expected_cmds.pop_front();
            if (rsp_window_out !== exp_r.window_out) begin
               $error("window_out expected %0d got %0d", exp_r.window_out, rsp_window_out);
               errors++;
            end
            if (rsp_motor_cmd !== exp_r.motor_cmd) begin
               $error("motor_cmd expected %0d got %0d", exp_r.motor_cmd, rsp_motor_cmd);
               errors++;
            end
            if (rsp_one_touch !== exp_r.one_touch) begin
               $error("one_touch expected %0d got %0d", exp_r.one_touch, rsp_one_touch);
               errors++;
            end
            if (rsp_locked !== exp_r.locked) begin
               $error("locked expected %0d got %0d", exp_r.locked, rsp_locked);
               errors++;
            end
         end
      end
   end

   initial begin
      lock_state = 1'b0;
      hold_cfg   = CNT_W'(HOLD_RESET);
      for (int k = 0; k < WINDOWS; k++) begin
         win_mode[k]   = MODE_IDLE;
         win_count[k]  = '0;
         win_motor[k]  = MOT_OFF;
         press_dir[k]  = 0;
         press_left[k] = 0;
         press_remote[k] = 1'b0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_hold();
      test_directed();
      test_random_holds();
      test_longest_hold();
      test_backpressure();
      test_no_gaps();
      wait_idle();
      repeat (10) @(negedge clock);
      if (expected_cmds.size() != 0) begin
         $error("%0d responses never arrived", expected_cmds.size());
         errors++;
      end
      $display("Covered %0d requests: reset hold, switch corner cases, hold 0..1023,",
               sent_count);
      $display("long response stall, drained pause and gap-free stretch; %0d mismatches",
               errors);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
